[rtl/lav_pkg.sv]
`timescale 1ns / 1ps
package lav_pkg;

	localparam int FRAC_BITS = 16;
	localparam int UNIT_W    = FRAC_BITS + 2;
	localparam int VEC_W     = UNIT_W + 33;
	localparam int POS_W     = $clog2(VEC_W);
	localparam int NRM_W     = 30;
	localparam int SUM_W     = 2 * NRM_W + 2;
	localparam int SQX_W     = 64;
	localparam int REM_W     = 35;
	localparam int ROOT_W    = 32;
	localparam int LEN_W     = 31;
	localparam int STEPS     = 4;
	localparam int SQ_ST     = (SQX_W / 2) / STEPS;
	localparam int QB        = FRAC_BITS + 1;
	localparam int DIV_ST    = (QB + STEPS - 1) / STEPS;
	localparam int ND_W      = NRM_W + FRAC_BITS + 1;
	localparam int DREM_W    = 32;
	localparam int NORM_LAT  = SQ_ST + DIV_ST + 7;
	localparam int PC_W      = UNIT_W + 32;
	localparam int DOT_W     = FRAC_BITS + 36;

	typedef logic signed [VEC_W-1:0]  vec_t;
	typedef logic signed [UNIT_W-1:0] unit_t;
	typedef logic signed [31:0]       word_t;
	typedef logic signed [DOT_W-1:0]  dot_t;

	function automatic dot_t rnd_shift(input dot_t v);
		logic [DOT_W-1:0] m;
		m = v[DOT_W-1] ? DOT_W'(-v) : DOT_W'(v);
		m = (m + (DOT_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		return v[DOT_W-1] ? -$signed(m) : $signed(m);
	endfunction

	function automatic word_t sat32(input dot_t v);
		if (v[DOT_W-1:31] == '0 || v[DOT_W-1:31] == '1)
			return v[31:0];
		else if (v[DOT_W-1])
			return 32'sh8000_0000;
		else
			return 32'sh7fff_ffff;
	endfunction

endpackage

[rtl/lav_norm.sv]
`timescale 1ns / 1ps
module lav_norm (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         in_valid,
	input  lav_pkg::vec_t  vec_in [3],
	output logic         out_valid,
	output lav_pkg::unit_t unit_out [3],
	output logic         zero_out
);
	import lav_pkg::*;

	function automatic logic [POS_W-1:0] lead_one(input logic [VEC_W-1:0] x);
		logic [POS_W-1:0] p;
		p = '0;
		for (int i = 0; i < VEC_W; i++)
			if (x[i])
				p = POS_W'(i);
		return p;
	endfunction

	// a: magnitudes and max
	logic             v_a;
	logic [VEC_W-1:0] m_a [3];
	logic [2:0]       neg_a;
	logic [VEC_W-1:0] big_a;
	// b: leading one
	logic             v_b;
	logic [VEC_W-1:0] m_b [3];
	logic [2:0]       neg_b;
	logic             zero_b;
	logic [POS_W-1:0] pos_b;
	// c: scaled
	logic             v_c;
	logic [NRM_W-1:0] n_c [3];
	logic [2:0]       neg_c;
	logic             zero_c;
	// d: squares
	logic             v_d;
	logic [NRM_W-1:0] n_d [3];
	logic [2*NRM_W-1:0] sq_d [3];
	logic [2:0]       neg_d;
	logic             zero_d;
	// sqrt pipe, index 0 is the sum stage
	logic             sv   [SQ_ST+1];
	logic [SQX_W-1:0] sx   [SQ_ST+1];
	logic [REM_W-1:0] srem [SQ_ST+1];
	logic [ROOT_W-1:0] sroot [SQ_ST+1];
	logic [NRM_W-1:0] sn   [SQ_ST+1][3];
	logic [2:0]       sneg [SQ_ST+1];
	logic             szero [SQ_ST+1];
	// divide pipe, index 0 is the dividend stage
	logic              dv   [DIV_ST+1];
	logic [ND_W-1:0]   dn   [DIV_ST+1][3];
	logic [DREM_W-1:0] drem [DIV_ST+1][3];
	logic [QB-1:0]     dq   [DIV_ST+1][3];
	logic [LEN_W-1:0]  dlen [DIV_ST+1];
	logic [2:0]        dneg [DIV_ST+1];
	logic              dzero [DIV_ST+1];

	logic [VEC_W-1:0] mag_in [3];
	logic [VEC_W-1:0] big_in;

	always_comb begin
		for (int i = 0; i < 3; i++)
			mag_in[i] = vec_in[i][VEC_W-1] ? VEC_W'(-vec_in[i]) : VEC_W'(vec_in[i]);
		big_in = mag_in[0];
		if (mag_in[1] > big_in)
			big_in = mag_in[1];
		if (mag_in[2] > big_in)
			big_in = mag_in[2];
	end

	logic [VEC_W-1:0] shf [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (pos_b >= POS_W'(NRM_W - 1))
				shf[i] = m_b[i] >> (pos_b - POS_W'(NRM_W - 1));
			else
				shf[i] = m_b[i] << (POS_W'(NRM_W - 1) - pos_b);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_a <= 1'b0;
			v_b <= 1'b0;
			v_c <= 1'b0;
			v_d <= 1'b0;
			for (int k = 0; k <= SQ_ST; k++)
				sv[k] <= 1'b0;
			for (int k = 0; k <= DIV_ST; k++)
				dv[k] <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_a <= in_valid;
			v_b <= v_a;
			v_c <= v_b;
			v_d <= v_c;
			sv[0] <= v_d;
			for (int k = 1; k <= SQ_ST; k++)
				sv[k] <= sv[k-1];
			dv[0] <= sv[SQ_ST];
			for (int k = 1; k <= DIV_ST; k++)
				dv[k] <= dv[k-1];
			out_valid <= dv[DIV_ST];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				m_a[i]   <= mag_in[i];
				neg_a[i] <= vec_in[i][VEC_W-1];
			end
			big_a <= big_in;

			m_b    <= m_a;
			neg_b  <= neg_a;
			zero_b <= (big_a == '0);
			pos_b  <= lead_one(big_a);

			for (int i = 0; i < 3; i++)
				n_c[i] <= shf[i][NRM_W-1:0];
			neg_c  <= neg_b;
			zero_c <= zero_b;

			for (int i = 0; i < 3; i++)
				sq_d[i] <= n_c[i] * n_c[i];
			n_d    <= n_c;
			neg_d  <= neg_c;
			zero_d <= zero_c;

			sx[0]    <= SQX_W'(SUM_W'(sq_d[0]) + SUM_W'(sq_d[1]) + SUM_W'(sq_d[2]));
			srem[0]  <= '0;
			sroot[0] <= '0;
			sn[0]    <= n_d;
			sneg[0]  <= neg_d;
			szero[0] <= zero_d;
		end
	end

	for (genvar k = 1; k <= SQ_ST; k++) begin : g_sqrt
		logic [SQX_W-1:0]  x_t;
		logic [REM_W-1:0]  r_t, trial;
		logic [ROOT_W-1:0] q_t;
		always_comb begin
			x_t = sx[k-1];
			r_t = srem[k-1];
			q_t = sroot[k-1];
			trial = '0;
			for (int j = 0; j < STEPS; j++) begin
				r_t = {r_t[REM_W-3:0], x_t[SQX_W-1:SQX_W-2]};
				x_t = x_t << 2;
				trial = REM_W'({q_t, 2'b01});
				if (r_t >= trial) begin
					r_t = r_t - trial;
					q_t = {q_t[ROOT_W-2:0], 1'b1};
				end else begin
					q_t = {q_t[ROOT_W-2:0], 1'b0};
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sx[k]    <= x_t;
				srem[k]  <= r_t;
				sroot[k] <= q_t;
				sn[k]    <= sn[k-1];
				sneg[k]  <= sneg[k-1];
				szero[k] <= szero[k-1];
			end
		end
	end

	logic [LEN_W-1:0] len_w;
	logic [ND_W-1:0]  nd_w [3];
	always_comb begin
		len_w = sroot[SQ_ST][LEN_W-1:0];
		for (int i = 0; i < 3; i++)
			nd_w[i] = {sn[SQ_ST][i], {FRAC_BITS{1'b0}}} + ND_W'(len_w >> 1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dn[0][i]   <= nd_w[i];
				drem[0][i] <= DREM_W'(nd_w[i][ND_W-1:QB]);
				dq[0][i]   <= '0;
			end
			dlen[0]  <= len_w;
			dneg[0]  <= sneg[SQ_ST];
			dzero[0] <= szero[SQ_ST];
		end
	end

	for (genvar k = 1; k <= DIV_ST; k++) begin : g_div
		logic [DREM_W-1:0] r_t [3];
		logic [QB-1:0]     q_t [3];
		logic [ND_W-1:0]   n_t;
		always_comb begin
			n_t = '0;
			for (int i = 0; i < 3; i++) begin
				r_t[i] = drem[k-1][i];
				q_t[i] = dq[k-1][i];
				n_t = dn[k-1][i] << ((k - 1) * STEPS);
				for (int j = 0; j < STEPS; j++) begin
					if ((k - 1) * STEPS + j < QB) begin
						r_t[i] = {r_t[i][DREM_W-2:0], n_t[QB-1]};
						if (r_t[i] >= DREM_W'(dlen[k-1])) begin
							r_t[i] = r_t[i] - DREM_W'(dlen[k-1]);
							q_t[i] = {q_t[i][QB-2:0], 1'b1};
						end else begin
							q_t[i] = {q_t[i][QB-2:0], 1'b0};
						end
					end
					n_t = n_t << 1;
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				drem[k]  <= r_t;
				dq[k]    <= q_t;
				dn[k]    <= dn[k-1];
				dlen[k]  <= dlen[k-1];
				dneg[k]  <= dneg[k-1];
				dzero[k] <= dzero[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (dzero[DIV_ST])
					unit_out[i] <= '0;
				else if (dneg[DIV_ST][i])
					unit_out[i] <= -$signed(UNIT_W'(dq[DIV_ST][i]));
				else
					unit_out[i] <= $signed(UNIT_W'(dq[DIV_ST][i]));
			end
			zero_out <= dzero[DIV_ST];
		end
	end

endmodule

[rtl/look_at_view_matrix_core.sv]
`timescale 1ns / 1ps
// channel | handshake              | payload
// in      | in_valid / in_ready    | eye_*, target_*, up_* (signed Q16.16)
// out     | out_valid / out_ready  | column_index, row0..3_value, last_column, degenerate
//
// One item gives four column transfers, columns 0 to 3, one per cycle while out_ready is
// high; the next item loads as the last column is taken. Most of the pipeline is the
// two normalizers' sqrt and divide stages. Reset clears the valid bits and the column
// counter only. A stall on the output freezes the whole pipeline; in_ready is low while
// the output holds an item not fully taken.
module look_at_view_matrix_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic signed [31:0] eye_x,
	input  logic signed [31:0] eye_y,
	input  logic signed [31:0] eye_z,
	input  logic signed [31:0] target_x,
	input  logic signed [31:0] target_y,
	input  logic signed [31:0] target_z,
	input  logic signed [31:0] up_x,
	input  logic signed [31:0] up_y,
	input  logic signed [31:0] up_z,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  column_index,
	output logic signed [31:0] row0_value,
	output logic signed [31:0] row1_value,
	output logic signed [31:0] row2_value,
	output logic signed [31:0] row3_value,
	output logic        last_column,
	output logic        degenerate
);
	import lav_pkg::*;

	localparam logic [1:0] LAST_COL = 2'd3;

	logic adv;

	logic  v_s1;
	word_t eye_s1 [3], up_s1 [3];
	vec_t  d_s1 [3];

	logic  n1_valid, n1_zero;
	unit_t f_n1 [3];
	word_t eye_d1 [NORM_LAT][3];
	word_t up_d1  [NORM_LAT][3];

	logic  v_s2, z_s2;
	logic signed [PC_W-1:0] pc_s2 [6];
	unit_t f_s2 [3];
	word_t eye_s2 [3];

	logic  v_s3, z_s3;
	vec_t  c_s3 [3];
	unit_t f_s3 [3];
	word_t eye_s3 [3];

	logic  n2_valid, n2_zero;
	unit_t s_n2 [3];
	unit_t f_d2 [NORM_LAT][3];
	word_t eye_d2 [NORM_LAT][3];
	logic  z_d2 [NORM_LAT];

	logic  v_s4, dg_s4;
	logic signed [2*UNIT_W-1:0] sf_s4 [6];
	logic signed [PC_W-1:0] se_s4 [3], fe_s4 [3];
	unit_t s_s4 [3], f_s4 [3];
	word_t eye_s4 [3];

	logic  v_s5, dg_s5;
	logic signed [UNIT_W:0] u_s5 [3];
	dot_t  ds_s5, df_s5;
	unit_t s_s5 [3], f_s5 [3];
	word_t eye_s5 [3];

	logic  v_s6, dg_s6;
	logic signed [PC_W:0] ue_s6 [3];
	dot_t  ds_s6, df_s6;
	unit_t s_s6 [3], f_s6 [3];
	logic signed [UNIT_W:0] u_s6 [3];

	logic  v_s7, dg_s7;
	word_t c3_s7 [3];
	unit_t s_s7 [3], f_s7 [3];
	logic signed [UNIT_W:0] u_s7 [3];

	logic       out_valid_q, degen_q;
	logic [1:0] col_q;
	word_t      mat_q [4][4];

	assign adv      = !out_valid_q || (out_ready && col_q == LAST_COL);
	assign in_ready = adv;

	lav_norm u_norm_f (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s1),
		.vec_in   (d_s1),
		.out_valid(n1_valid),
		.unit_out (f_n1),
		.zero_out (n1_zero)
	);

	lav_norm u_norm_s (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s3),
		.vec_in   (c_s3),
		.out_valid(n2_valid),
		.unit_out (s_n2),
		.zero_out (n2_zero)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= n1_valid;
			v_s3 <= v_s2;
			v_s4 <= n2_valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			eye_s1[0] <= eye_x;
			eye_s1[1] <= eye_y;
			eye_s1[2] <= eye_z;
			up_s1[0]  <= up_x;
			up_s1[1]  <= up_y;
			up_s1[2]  <= up_z;
			d_s1[0]   <= VEC_W'(target_x) - VEC_W'(eye_x);
			d_s1[1]   <= VEC_W'(target_y) - VEC_W'(eye_y);
			d_s1[2]   <= VEC_W'(target_z) - VEC_W'(eye_z);

			eye_d1[0] <= eye_s1;
			up_d1[0]  <= up_s1;
			for (int k = 1; k < NORM_LAT; k++) begin
				eye_d1[k] <= eye_d1[k-1];
				up_d1[k]  <= up_d1[k-1];
			end

			// f x up partial products
			pc_s2[0] <= f_n1[1] * up_d1[NORM_LAT-1][2];
			pc_s2[1] <= f_n1[2] * up_d1[NORM_LAT-1][1];
			pc_s2[2] <= f_n1[2] * up_d1[NORM_LAT-1][0];
			pc_s2[3] <= f_n1[0] * up_d1[NORM_LAT-1][2];
			pc_s2[4] <= f_n1[0] * up_d1[NORM_LAT-1][1];
			pc_s2[5] <= f_n1[1] * up_d1[NORM_LAT-1][0];
			f_s2   <= f_n1;
			eye_s2 <= eye_d1[NORM_LAT-1];
			z_s2   <= n1_zero;

			c_s3[0] <= VEC_W'(pc_s2[0]) - VEC_W'(pc_s2[1]);
			c_s3[1] <= VEC_W'(pc_s2[2]) - VEC_W'(pc_s2[3]);
			c_s3[2] <= VEC_W'(pc_s2[4]) - VEC_W'(pc_s2[5]);
			f_s3   <= f_s2;
			eye_s3 <= eye_s2;
			z_s3   <= z_s2;

			f_d2[0]   <= f_s3;
			eye_d2[0] <= eye_s3;
			z_d2[0]   <= z_s3;
			for (int k = 1; k < NORM_LAT; k++) begin
				f_d2[k]   <= f_d2[k-1];
				eye_d2[k] <= eye_d2[k-1];
				z_d2[k]   <= z_d2[k-1];
			end

			sf_s4[0] <= s_n2[1] * f_d2[NORM_LAT-1][2];
			sf_s4[1] <= s_n2[2] * f_d2[NORM_LAT-1][1];
			sf_s4[2] <= s_n2[2] * f_d2[NORM_LAT-1][0];
			sf_s4[3] <= s_n2[0] * f_d2[NORM_LAT-1][2];
			sf_s4[4] <= s_n2[0] * f_d2[NORM_LAT-1][1];
			sf_s4[5] <= s_n2[1] * f_d2[NORM_LAT-1][0];
			for (int i = 0; i < 3; i++) begin
				se_s4[i] <= s_n2[i] * eye_d2[NORM_LAT-1][i];
				fe_s4[i] <= f_d2[NORM_LAT-1][i] * eye_d2[NORM_LAT-1][i];
			end
			s_s4   <= s_n2;
			f_s4   <= f_d2[NORM_LAT-1];
			eye_s4 <= eye_d2[NORM_LAT-1];
			dg_s4  <= z_d2[NORM_LAT-1] || n2_zero;

			for (int i = 0; i < 3; i++)
				u_s5[i] <= (UNIT_W+1)'(rnd_shift(DOT_W'(sf_s4[2*i])
					- DOT_W'(sf_s4[2*i+1])));
			ds_s5  <= DOT_W'(se_s4[0]) + DOT_W'(se_s4[1]) + DOT_W'(se_s4[2]);
			df_s5  <= DOT_W'(fe_s4[0]) + DOT_W'(fe_s4[1]) + DOT_W'(fe_s4[2]);
			s_s5   <= s_s4;
			f_s5   <= f_s4;
			eye_s5 <= eye_s4;
			dg_s5  <= dg_s4;

			for (int i = 0; i < 3; i++)
				ue_s6[i] <= u_s5[i] * eye_s5[i];
			ds_s6 <= ds_s5;
			df_s6 <= df_s5;
			s_s6  <= s_s5;
			u_s6  <= u_s5;
			f_s6  <= f_s5;
			dg_s6 <= dg_s5;

			c3_s7[0] <= sat32(-rnd_shift(ds_s6));
			c3_s7[1] <= sat32(-rnd_shift(DOT_W'(ue_s6[0]) + DOT_W'(ue_s6[1])
				+ DOT_W'(ue_s6[2])));
			c3_s7[2] <= sat32(rnd_shift(df_s6));
			s_s7  <= s_s6;
			u_s7  <= u_s6;
			f_s7  <= f_s6;
			dg_s7 <= dg_s6;
		end
	end

	// output column buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			col_q       <= '0;
		end else if (adv) begin
			out_valid_q <= v_s7;
			col_q       <= '0;
		end else if (out_ready) begin
			col_q <= col_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			degen_q <= dg_s7;
			for (int k = 0; k < 3; k++) begin
				mat_q[k][0] <= dg_s7 ? '0 : 32'(s_s7[k]);
				mat_q[k][1] <= dg_s7 ? '0 : 32'(u_s7[k]);
				mat_q[k][2] <= dg_s7 ? '0 : -32'(f_s7[k]);
				mat_q[k][3] <= '0;
			end
			for (int r = 0; r < 3; r++)
				mat_q[3][r] <= dg_s7 ? '0 : c3_s7[r];
			mat_q[3][3] <= dg_s7 ? '0 : (32'sd1 <<< FRAC_BITS);
		end
	end

	assign out_valid    = out_valid_q;
	assign column_index = col_q;
	assign row0_value   = mat_q[col_q][0];
	assign row1_value   = mat_q[col_q][1];
	assign row2_value   = mat_q[col_q][2];
	assign row3_value   = mat_q[col_q][3];
	assign last_column  = (col_q == LAST_COL);
	assign degenerate   = degen_q;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
	import lav_pkg::*;

	localparam int LAT = 2 * NORM_LAT + 8;
	localparam int N_RAND = 340;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [1:0]   col;
		logic [31:0]  r0;
		logic [31:0]  r1;
		logic [31:0]  r2;
		logic [31:0]  r3;
		logic         last;
		logic         degen;
	} column_t;

	typedef struct {
		logic signed [31:0] v [9];
		logic               has_gold;
		logic               gold_degen;
	} stim_t;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_ready;
	logic signed [31:0] eye_x = 0, eye_y = 0, eye_z = 0;
	logic signed [31:0] target_x = 0, target_y = 0, target_z = 0;
	logic signed [31:0] up_x = 0, up_y = 0, up_z = 0;
	logic out_valid, out_ready = 0;
	logic [1:0] column_index;
	logic signed [31:0] row0_value, row1_value, row2_value, row3_value;
	logic last_column, degenerate;

	column_t column_q[$];
	int errors = 0;
	int cycles = 0;
	bit hold_rx = 0;
	bit stim_done = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	look_at_view_matrix_core u_dut (.*);

	function automatic logic [63:0] isqrt(input logic [63:0] x);
		logic [63:0] res, bit_v;
		res = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > x) bit_v >>= 2;
		while (bit_v != 0) begin
			if (x >= res + bit_v) begin
				x -= res + bit_v;
				res = (res >> 1) + bit_v;
			end else begin
				res >>= 1;
			end
			bit_v >>= 2;
		end
		return res;
	endfunction

	function automatic bit unit_vec(input longint v [3], output longint o [3]);
		logic [63:0] m [3];
		logic [63:0] big, sum, len, q;
		int rs, ls;
		big = 0; sum = 0; rs = 0; ls = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = v[i] < 0 ? -v[i] : v[i];
			if (m[i] > big) big = m[i];
		end
		if (big == 0) return 0;
		while (big >= (64'd1 << 30)) begin big >>= 1; rs++; end
		while (big < (64'd1 << 29)) begin big <<= 1; ls++; end
		for (int i = 0; i < 3; i++) begin
			m[i] = (m[i] >> rs) << ls;
			sum += m[i] * m[i];
		end
		len = isqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << FRAC_BITS) + (len >> 1)) / len;
			o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
		end
		return 1;
	endfunction

	function automatic longint rshift(input longint v);
		logic [63:0] m;
		m = v < 0 ? -v : v;
		m = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		return v < 0 ? -longint'(m) : longint'(m);
	endfunction

	function automatic logic [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647) return 32'h7fff_ffff;
		if (v < -64'sd2147483648) return 32'h8000_0000;
		return v[31:0];
	endfunction

	task automatic predict_view(input logic signed [31:0] v [9]);
		longint eye [3], up [3], d [3], f [3], c [3], s [3], u [3];
		longint cm [4][4];
		longint ds, du, df;
		bit degen;
		column_t e;
		ds = 0; du = 0; df = 0; degen = 0;
		for (int i = 0; i < 3; i++) begin
			eye[i] = v[i];
			d[i] = longint'(v[3+i]) - eye[i];
			up[i] = v[6+i];
		end
		foreach (cm[k, i]) cm[k][i] = 0;
		if (!unit_vec(d, f)) begin
			degen = 1;
		end else begin
			c[0] = f[1] * up[2] - f[2] * up[1];
			c[1] = f[2] * up[0] - f[0] * up[2];
			c[2] = f[0] * up[1] - f[1] * up[0];
			if (!unit_vec(c, s)) degen = 1;
		end
		if (!degen) begin
			u[0] = rshift(s[1] * f[2] - s[2] * f[1]);
			u[1] = rshift(s[2] * f[0] - s[0] * f[2]);
			u[2] = rshift(s[0] * f[1] - s[1] * f[0]);
			for (int i = 0; i < 3; i++) begin
				ds += s[i] * eye[i];
				du += u[i] * eye[i];
				df += f[i] * eye[i];
				cm[i][0] = s[i];
				cm[i][1] = u[i];
				cm[i][2] = -f[i];
			end
			cm[3][0] = -rshift(ds);
			cm[3][1] = -rshift(du);
			cm[3][2] = rshift(df);
			cm[3][3] = longint'(1) << FRAC_BITS;
		end
		for (int k = 0; k < 4; k++) begin
			e.col = 2'(k);
			e.r0 = clamp32(cm[k][0]);
			e.r1 = clamp32(cm[k][1]);
			e.r2 = clamp32(cm[k][2]);
			e.r3 = clamp32(cm[k][3]);
			e.last = (k == 3);
			e.degen = degen;
			column_q.push_back(e);
		end
	endtask

	task automatic report(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		errors++;
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// stimulus table: directed rows, gold degenerate flag where obvious
	stim_t dir_rows[$];

	function automatic stim_t row(input logic signed [31:0] a [9], input logic g,
			input logic gd);
		stim_t r;
		r.v = a;
		r.has_gold = g;
		r.gold_degen = gd;
		return r;
	endfunction

	task automatic build_table();
		logic signed [31:0] mx, mn, one;
		mx = 32'sh7fff_ffff; mn = 32'sh8000_0000; one = 32'sh1_0000;
		dir_rows.push_back(row('{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, 1));
		dir_rows.push_back(row('{5, 6, 7, 5, 6, 7, 0, one, 0}, 1, 1));
		dir_rows.push_back(row('{0, 0, 0, 0, 0, -one, 0, 0, 0}, 1, 1));
		dir_rows.push_back(row('{0, 0, 0, 0, 0, -one, 0, 0, one}, 1, 1));
		dir_rows.push_back(row('{0, 0, 0, 0, 0, -one, 0, 0, mn}, 1, 1));
		dir_rows.push_back(row('{0, 0, 0, 0, 0, -one, 0, one, 0}, 0, 0));
		dir_rows.push_back(row('{0, 0, one, 0, 0, 0, 0, one, 0}, 0, 0));
		dir_rows.push_back(row('{mx, mx, mx, mn, mn, mn, 0, one, 0}, 0, 0));
		dir_rows.push_back(row('{mn, mn, mn, mx, mx, mx, mx, mn, 0}, 0, 0));
		dir_rows.push_back(row('{mx, mn, mx, mn, mx, mn, mn, mn, mx}, 0, 0));
		dir_rows.push_back(row('{mx, 0, 0, mn, 0, 0, 0, mx, 0}, 0, 0));
		dir_rows.push_back(row('{0, mn, 0, 0, mx, 0, mn, 0, 0}, 0, 0));
		dir_rows.push_back(row('{0, 0, mx, 1, 0, mx, 0, 0, 1}, 0, 0));
		dir_rows.push_back(row('{-1, -1, -1, 0, 0, 0, 1, 0, 0}, 0, 0));
		dir_rows.push_back(row('{mx, mx, mx, mx - 1, mx, mx, 0, 1, 0}, 0, 0));
		dir_rows.push_back(row('{mn, mx, mn, mn + 3, mx - 4, mn + 5, mx, mx, mn}, 0, 0));
		dir_rows.push_back(row('{-one, -one, -one, -1, -1, -1, -1, -1, -1}, 1, 1));
	endtask

	task automatic gen_random(output logic signed [31:0] a [9]);
		int mode;
		mode = $urandom_range(0, 9);
		for (int i = 0; i < 9; i++) begin
			case (mode)
				0, 1, 2, 3: a[i] = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh10_0000;
				4: a[i] = $urandom_range(0, 1) ? 32'sh7fff_ffff - $urandom_range(0, 3)
					: 32'sh8000_0000 + $urandom_range(0, 3);
				5: a[i] = $signed($urandom_range(0, 15)) - 8;
				default: a[i] = $urandom;
			endcase
		end
		if ($urandom_range(0, 19) == 0) for (int i = 0; i < 3; i++) a[3+i] = a[i];
		if ($urandom_range(0, 19) == 0)
			for (int i = 0; i < 3; i++) a[6+i] = (a[3+i] - a[i]) * $urandom_range(1, 2);
	endtask

	task automatic send_item(input logic signed [31:0] a [9]);
		eye_x <= a[0]; eye_y <= a[1]; eye_z <= a[2];
		target_x <= a[3]; target_y <= a[4]; target_z <= a[5];
		up_x <= a[6]; up_y <= a[7]; up_z <= a[8];
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		predict_view(a);
	endtask

	task automatic tx_gap();
		int g;
		g = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	initial begin
		logic signed [31:0] a [9];
		column_t g;
		build_table();
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (dir_rows[n]) begin
			send_item(dir_rows[n].v);
			if (dir_rows[n].has_gold) begin
				for (int k = 1; k <= 4; k++) begin
					g = column_q[column_q.size() - k];
					if (g.degen !== dir_rows[n].gold_degen || (g.degen &&
							{g.r0, g.r1, g.r2, g.r3} !== '0))
						report($sformatf("directed row %0d: degenerate case mispredicted", n));
				end
			end
			tx_gap();
		end
		for (int n = 0; n < N_RAND; n++) begin
			if (n == 100) begin
				hold_rx = 1;
			end
			if (n == 200) begin
				in_valid <= 0;
				while (column_q.size() != 0) @(posedge clk);
			end
			gen_random(a);
			send_item(a);
			if (n < 100 || n >= 130) tx_gap();
		end
		in_valid <= 0;
		stim_done = 1;
	end

	// receiver: per-column wait, plus a long hold-off while hold_rx is set
	initial begin
		int w;
		int hold_cnt;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_rx) begin
				hold_cnt = 0;
				out_ready <= 0;
				while (hold_cnt < 300) begin
					@(posedge clk);
					hold_cnt++;
				end
				hold_rx = 0;
			end
			if (out_ready && out_valid) begin
				w = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 10);
				if (w > 0) out_ready <= 0;
				repeat (w) @(posedge clk);
				out_ready <= 1;
			end else begin
				out_ready <= 1;
			end
		end
	end

	always @(posedge clk) begin
		column_t e;
		if (arst_n && out_valid && out_ready) begin
			if (column_q.size() == 0) begin
				report("column transfer with nothing expected");
			end else begin
				e = column_q.pop_front();
				if (column_index !== e.col)
					report($sformatf("column_index %0d exp %0d", column_index, e.col));
				if (row0_value !== e.r0)
					report($sformatf("col %0d row0 %h exp %h", e.col, row0_value, e.r0));
				if (row1_value !== e.r1)
					report($sformatf("col %0d row1 %h exp %h", e.col, row1_value, e.r1));
				if (row2_value !== e.r2)
					report($sformatf("col %0d row2 %h exp %h", e.col, row2_value, e.r2));
				if (row3_value !== e.r3)
					report($sformatf("col %0d row3 %h exp %h", e.col, row3_value, e.r3));
				if (last_column !== e.last)
					report($sformatf("col %0d last_column %b", e.col, last_column));
				if (degenerate !== e.degen)
					report($sformatf("col %0d degenerate %b exp %b", e.col, degenerate,
						e.degen));
			end
		end
	end

	initial begin
		wait (stim_done);
		while (column_q.size() != 0) @(posedge clk);
		repeat (LAT + 20) @(posedge clk);
		if (errors == 0 && column_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[look_at_view_matrix_core.f]
rtl/lav_pkg.sv
rtl/lav_norm.sv
rtl/look_at_view_matrix_core.sv
tb/tb_top.sv
